>>> hw/rtl/rcd_pkg.sv
// Shared types and constants of the run-length channel decoder.
// Used by rcd_front, rcd_fifo, rcd_back and rle_channel_decoder_core.
package rcd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WIDTH_W     = 16;
    localparam int unsigned POS_W       = 18;
    localparam int unsigned COUNT_W     = 2;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST    = 16'd640;
    localparam logic [WIDTH_W-1:0] VISIBLE_WIDTH_RST = 16'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH    = 1'b0,
        CFG_VISIBLE_WIDTH = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_RUN     = 2'd1,
        MODE_LITERAL = 2'd2
    } t_mode;

    // One expansion job: a pixel value repeated npix times from start_pos.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] npix;
        logic [POS_W-1:0]  start_pos;
        logic              eol;
    } t_job;

endpackage

>>> hw/rtl/rle_channel_decoder_core.sv
// Top level of the run-length channel decoder: front end, job queue, back end.
// Depends on rcd_pkg, rcd_front, rcd_fifo and rcd_back.
//
//  port group    direction  beat
//  i_code_*      in         one compressed byte (header, run value or literal)
//  o_res_*/pix   out        up to two decoded pixels with count, byte and line flags
//  i_cfg_*       in         register write (0: line width, 1: visible width)
//
// A header byte yields no beat. A run value byte of n pixels becomes one job that
// the back end loads and expands in pairs; a literal byte becomes a one-pixel job.
// The back end's pair-per-cycle expansion, while o_res is not stalled, sets the rate;
// the queue lets the front take bytes while a run drains. Reset is synchronous, active
// low, restoring both widths to 640. Data bytes stall when the job queue is full.
module rle_channel_decoder_core #(
    parameter int unsigned QueueDepth = rcd_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rcd_pkg::BYTE_W-1:0]    i_code_byte,
    input  logic                          i_code_valid,
    output logic                          o_code_stall,
    input  logic                          i_cfg_wr_en,
    input  logic [rcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rcd_pkg::WIDTH_W-1:0]   i_cfg_data,
    output logic [rcd_pkg::BYTE_W-1:0]    o_pixel_first,
    output logic [rcd_pkg::BYTE_W-1:0]    o_pixel_second,
    output logic [rcd_pkg::COUNT_W-1:0]   o_pixel_count,
    output logic                          o_last_of_byte,
    output logic                          o_end_of_line,
    output logic                          o_res_valid,
    input  logic                          i_res_stall
);
    import rcd_pkg::*;

    logic q_push, q_pop, q_full, q_empty;
    t_job push_job, head_job;

    rcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_code_byte  (i_code_byte),
        .i_code_valid (i_code_valid),
        .o_code_stall (o_code_stall),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_job      (push_job)
    );

    rcd_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    rcd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_empty      (q_empty),
        .i_q_job        (head_job),
        .o_q_pop        (q_pop),
        .o_pixel_first  (o_pixel_first),
        .o_pixel_second (o_pixel_second),
        .o_pixel_count  (o_pixel_count),
        .o_last_of_byte (o_last_of_byte),
        .o_end_of_line  (o_end_of_line),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall)
    );

endmodule

>>> hw/rtl/rcd_front.sv
// Front end: accepts code bytes, parses packet headers, tracks line state
// and pushes expansion jobs. Depends on rcd_pkg.
module rcd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rcd_pkg::BYTE_W-1:0]    i_code_byte,
    input  logic                          i_code_valid,
    output logic                          o_code_stall,
    input  logic                          i_cfg_wr_en,
    input  logic [rcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rcd_pkg::WIDTH_W-1:0]   i_cfg_data,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output rcd_pkg::t_job                 o_q_job
);
    import rcd_pkg::*;

    t_mode                     r_mode, n_mode;
    logic [BYTE_W-1:0]         r_pending, n_pending;
    logic signed [POS_W-1:0]   r_pixels_left, n_pixels_left;
    logic [POS_W-1:0]          r_pos, n_pos;
    logic [WIDTH_W-1:0]        r_line_width;

    logic                      is_data;
    logic                      accept;
    logic                      pkt_end;
    logic                      line_end;
    logic [BYTE_W-1:0]         job_n;
    logic signed [POS_W-1:0]   left_diff;

    assign is_data      = (r_mode == MODE_RUN) || (r_mode == MODE_LITERAL);
    assign o_code_stall = is_data && i_q_full;
    assign accept       = i_code_valid && !o_code_stall;

    assign job_n     = (r_mode == MODE_RUN) ? r_pending : BYTE_W'(1);
    assign left_diff = r_pixels_left - $signed({{(POS_W-BYTE_W){1'b0}}, job_n});
    assign pkt_end   = (r_mode == MODE_RUN) || (r_pending == BYTE_W'(1));
    assign line_end  = pkt_end && (left_diff[POS_W-1] || (left_diff == '0));

    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_HEADER: begin
                if (accept) n_mode = i_code_byte[BYTE_W-1] ? MODE_LITERAL : MODE_RUN;
            end
            MODE_RUN: begin
                if (accept) n_mode = MODE_HEADER;
            end
            MODE_LITERAL: begin
                if (accept && pkt_end) n_mode = MODE_HEADER;
            end
            default: n_mode = MODE_HEADER;
        endcase
    end

    always_comb begin
        n_pending     = r_pending;
        n_pixels_left = r_pixels_left;
        n_pos         = r_pos;
        o_q_push      = accept && is_data;
        o_q_job.value     = i_code_byte;
        o_q_job.npix      = job_n;
        o_q_job.start_pos = r_pos;
        o_q_job.eol       = line_end;
        if (accept) begin
            if (!is_data) begin
                n_pending = i_code_byte[BYTE_W-1] ? BYTE_W'(~i_code_byte + BYTE_W'(1))
                                                  : BYTE_W'(i_code_byte + BYTE_W'(1));
            end else begin
                n_pending = pkt_end ? '0 : BYTE_W'(r_pending - BYTE_W'(1));
                if (line_end) begin
                    n_pixels_left = $signed({{(POS_W-WIDTH_W){1'b0}}, r_line_width});
                    n_pos         = '0;
                end else begin
                    n_pixels_left = left_diff;
                    n_pos         = POS_W'(r_pos + {{(POS_W-BYTE_W){1'b0}}, job_n});
                end
            end
        end
        if (i_cfg_wr_en && (i_cfg_index == CFG_LINE_WIDTH) && (r_pos == '0)) begin
            n_pixels_left = $signed({{(POS_W-WIDTH_W){1'b0}}, i_cfg_data});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_HEADER;
            r_pending     <= '0;
            r_pixels_left <= $signed({{(POS_W-WIDTH_W){1'b0}}, LINE_WIDTH_RST});
            r_pos         <= '0;
            r_line_width  <= LINE_WIDTH_RST;
        end else begin
            r_mode        <= n_mode;
            r_pending     <= n_pending;
            r_pixels_left <= n_pixels_left;
            r_pos         <= n_pos;
            if (i_cfg_wr_en && (i_cfg_index == CFG_LINE_WIDTH)) begin
                r_line_width <= i_cfg_data;
            end
        end
    end

    a_pending_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_HEADER) |-> (r_pending != '0))
        else $error("packet in progress with no pixels owed");

    a_line_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == '0) |-> (r_pixels_left == $signed({{(POS_W-WIDTH_W){1'b0}}, r_line_width})))
        else $error("line start without full pixel budget");

endmodule

>>> hw/rtl/rcd_fifo.sv
// Short job queue between front end and back end.
// Depends on rcd_pkg for the job type.
module rcd_fifo #(
    parameter int unsigned Depth = rcd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rcd_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output rcd_pkg::t_job o_job
);
    import rcd_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    t_job              r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]   r_count, n_count;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = CntW'(r_count + CntW'(1));
        else if (!i_push && i_pop) n_count = CntW'(r_count - CntW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : PtrW'(r_wr_ptr + PtrW'(1));
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : PtrW'(r_rd_ptr + PtrW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job popped from empty queue");

endmodule

>>> hw/rtl/rcd_back.sv
// Back end: expands queued jobs into pixel pairs, clips against the visible
// width and holds each result in an output register. Depends on rcd_pkg.
module rcd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [rcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rcd_pkg::WIDTH_W-1:0]   i_cfg_data,
    input  logic                          i_q_empty,
    input  rcd_pkg::t_job                 i_q_job,
    output logic                          o_q_pop,
    output logic [rcd_pkg::BYTE_W-1:0]    o_pixel_first,
    output logic [rcd_pkg::BYTE_W-1:0]    o_pixel_second,
    output logic [rcd_pkg::COUNT_W-1:0]   o_pixel_count,
    output logic                          o_last_of_byte,
    output logic                          o_end_of_line,
    output logic                          o_res_valid,
    input  logic                          i_res_stall
);
    import rcd_pkg::*;

    logic [WIDTH_W-1:0] r_visible_width;
    logic               r_busy;
    logic [BYTE_W-1:0]  r_value;
    logic [BYTE_W-1:0]  r_left;
    logic [POS_W-1:0]   r_pos;
    logic               r_eol;

    logic [BYTE_W-1:0]  r_o_first, r_o_second;
    logic [COUNT_W-1:0] r_o_count;
    logic               r_o_last, r_o_eol, r_o_valid;

    logic               out_free;
    logic               emit;
    logic               two;
    logic               last;
    logic               kept0, kept1;
    logic [POS_W-1:0]   pos_next;
    logic [POS_W-1:0]   vis_ext;
    logic [COUNT_W-1:0] cnt;

    assign out_free = !r_o_valid || !i_res_stall;
    assign emit     = r_busy && out_free;
    assign o_q_pop  = !r_busy && !i_q_empty;

    assign vis_ext  = {{(POS_W-WIDTH_W){1'b0}}, r_visible_width};
    assign pos_next = POS_W'(r_pos + POS_W'(1));
    assign two      = (r_left >= BYTE_W'(2));
    assign last     = !two || (r_left == BYTE_W'(2));
    assign kept0    = (r_pos < vis_ext);
    assign kept1    = two && (pos_next < vis_ext);
    assign cnt      = COUNT_W'({1'b0, kept0}) + COUNT_W'({1'b0, kept1});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visible_width <= VISIBLE_WIDTH_RST;
            r_busy          <= 1'b0;
            r_o_valid       <= 1'b0;
        end else begin
            if (i_cfg_wr_en && (i_cfg_index == CFG_VISIBLE_WIDTH)) begin
                r_visible_width <= i_cfg_data;
            end
            if (o_q_pop) begin
                r_busy <= 1'b1;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_value <= i_q_job.value;
            r_left  <= i_q_job.npix;
            r_pos   <= i_q_job.start_pos;
            r_eol   <= i_q_job.eol;
        end else if (emit) begin
            r_left <= two ? BYTE_W'(r_left - BYTE_W'(2)) : '0;
            r_pos  <= POS_W'(r_pos + POS_W'(2));
        end
        if (emit) begin
            r_o_first  <= (cnt != '0) ? r_value : '0;
            r_o_second <= (cnt == COUNT_W'(2)) ? r_value : '0;
            r_o_count  <= cnt;
            r_o_last   <= last;
            r_o_eol    <= r_eol;
        end
    end

    assign o_pixel_first  = r_o_first;
    assign o_pixel_second = r_o_second;
    assign o_pixel_count  = r_o_count;
    assign o_last_of_byte = r_o_last;
    assign o_end_of_line  = r_o_eol;
    assign o_res_valid    = r_o_valid;

    a_busy_owes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != '0))
        else $error("expansion active with nothing left");

    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_count != COUNT_W'(2))) |-> (r_o_second == '0))
        else $error("second pixel not cleared");

endmodule
